>>> rtl/ect_pkg.sv
package ect_pkg;

  localparam int unsigned KindW = 3;
  localparam int unsigned EvW   = 32;
  localparam int unsigned ConnW = 16;
  localparam int unsigned SeqW  = 48;

  localparam logic [KindW-1:0] KIND_RECORD  = 3'd0;
  localparam logic [KindW-1:0] KIND_DESTROY = 3'd1;
  localparam logic [KindW-1:0] KIND_COLLECT = 3'd2;
  localparam logic [KindW-1:0] KIND_QUERY   = 3'd3;
  localparam logic [KindW-1:0] KIND_ISSUED  = 3'd4;
  localparam logic [KindW-1:0] KIND_DRAINED = 3'd5;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [EvW-1:0]   event_id;
    logic [ConnW-1:0] conn_id;
    logic [SeqW-1:0]  seq;
    logic             query_ok;
    logic             seq_zero;
  } req_t;

endpackage

>>> rtl/ect_front.sv
// Input side: registers each beat into a two-entry queue for the back end.
module ect_front
  import ect_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KindW-1:0]     in_kind,
  input  logic [EvW-1:0]       in_event_id,
  input  logic [ConnW-1:0]     in_conn_id,
  input  logic [SeqW-1:0]      in_recorded_seq,
  input  logic                 in_query_ok,
  input  logic [SeqW-1:0]      in_drained_count,
  output logic                 req_valid,
  output req_t                 req,
  input  logic                 req_take
);

  req_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_en;
  req_t       incoming;

  assign in_stall  = (cnt_r == 2'd2);
  assign wr_en     = in_valid && !in_stall;
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_r];

  always_comb begin
    incoming.kind     = in_kind;
    incoming.event_id = in_event_id;
    incoming.conn_id  = in_conn_id;
    // The drain count rides in the sequence field, since kinds never need both.
    incoming.seq      = (in_kind == KIND_DRAINED) ? in_drained_count : in_recorded_seq;
    incoming.query_ok = in_query_ok;
    incoming.seq_zero = (in_recorded_seq == '0);
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, req_take};
    rd_nxt  = req_take ? !rd_r : rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[rd_r ^ cnt_r[0]] <= incoming;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |-> req_valid) else $error("take from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !req_take) |=> in_stall) else $error("full queue not stalling");
`endif

endmodule

>>> rtl/ect_back.sv
// Back end: walks the slot table one slot per cycle while not stalled.
module ect_back
  import ect_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  req_t             req,
  output logic             req_take,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [EvW-1:0]   out_batch_event,
  output logic [SeqW-1:0]  out_batch_seq,
  output logic             out_last,
  output logic             out_known_locally,
  output logic [SeqW-1:0]  out_issued_count
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] ILAST = IW'(SLOTS - 1);
  localparam logic [CW-1:0] CMAX  = CW'(SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PRIM  = 3'd2;
  localparam logic [2:0] S_OTHER = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [EvW-1:0]   sev_r   [SLOTS];
  logic [SeqW-1:0]  srec_r  [SLOTS];
  logic [SeqW-1:0]  scmp_r  [SLOTS];
  logic [ConnW-1:0] sconn_r [SLOTS];

  logic [2:0]      st_r;
  req_t            cur_r;
  logic [IW-1:0]   idx_r;
  logic [IW-1:0]   vic_r;
  logic [SeqW-1:0] vseq_r;
  logic [EvW-1:0]  hev_r;
  logic [SeqW-1:0] pseq_r;
  logic [CW-1:0]   count_r;
  logic [SeqW-1:0] ctr_r, issued_r, drained_r;

  logic            ov_r, olast_r, oknown_r;
  logic [EvW-1:0]  oev_r;
  logic [SeqW-1:0] oseq_r;
  logic [SeqW-1:0] oissued_r;
  logic            out_free;
  logic            ld_out;

  logic [EvW-1:0]   e_i;
  logic [SeqW-1:0]  r_i, c_i;
  logic [ConnW-1:0] n_i;
  logic             hit, idx_end, done_i, other_ok, prim_known;

  assign out_free = !ov_r || !out_stall;
  assign e_i = sev_r[idx_r];
  assign r_i = srec_r[idx_r];
  assign c_i = scmp_r[idx_r];
  assign n_i = sconn_r[idx_r];
  assign hit = (e_i == cur_r.event_id);
  assign idx_end = (idx_r == ILAST);
  assign other_ok = (e_i != '0) && !hit && (r_i != c_i) && (n_i == cur_r.conn_id);
  assign prim_known = hit && (issued_r == drained_r) && (r_i == c_i);
  assign req_take = (st_r == S_IDLE) && req_valid;

  // A beat is loaded into the output register in this cycle.
  assign ld_out = out_free && ((st_r == S_PRIM && prim_known) ||
                               (st_r == S_OTHER && count_r != CMAX && other_ok) ||
                               st_r == S_FLUSH || st_r == S_EMIT);

  assign out_valid         = ov_r;
  assign out_batch_event   = oev_r;
  assign out_batch_seq     = oseq_r;
  assign out_last          = olast_r;
  assign out_known_locally = oknown_r;
  assign out_issued_count  = oissued_r;

  // Scan stop for non-collect kinds.
  always_comb begin
    done_i = idx_end;
    unique case (cur_r.kind)
      KIND_RECORD: done_i = hit || idx_end;
      KIND_QUERY:  done_i = (hit && r_i == cur_r.seq) || idx_end;
      default:     done_i = idx_end;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ov_r      <= 1'b0;
      count_r   <= '0;
      ctr_r     <= '0;
      issued_r  <= '0;
      drained_r <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        sev_r[k]   <= '0;
        srec_r[k]  <= '0;
        scmp_r[k]  <= '0;
        sconn_r[k] <= '0;
      end
    end else begin
      ov_r <= ld_out || (ov_r && out_stall);
      unique case (st_r)
        S_IDLE: begin
          if (req_valid) begin
            cur_r   <= req;
            idx_r   <= '0;
            vic_r   <= '0;
            vseq_r  <= srec_r[0];
            hev_r   <= req.event_id;
            pseq_r  <= '0;
            count_r <= CW'(1);
            if (req.kind == KIND_RECORD) ctr_r <= ctr_r + 1'b1;
            if (req.kind == KIND_COLLECT) st_r <= S_PRIM;
            else if (req.kind == KIND_DESTROY || req.kind == KIND_RECORD ||
                     (req.kind == KIND_QUERY && req.query_ok && !req.seq_zero))
              st_r <= S_SCAN;
            else begin
              if (req.kind == KIND_ISSUED) issued_r <= issued_r + 1'b1;
              if (req.kind == KIND_DRAINED) drained_r <= req.seq;
              st_r <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          case (cur_r.kind)
            KIND_RECORD: begin
              if (hit) begin
                srec_r[idx_r]  <= ctr_r;
                sconn_r[idx_r] <= cur_r.conn_id;
              end else if (idx_end) begin
                if (r_i < vseq_r) begin
                  sev_r[idx_r] <= cur_r.event_id; srec_r[idx_r] <= ctr_r;
                  scmp_r[idx_r] <= '0; sconn_r[idx_r] <= cur_r.conn_id;
                end else begin
                  sev_r[vic_r] <= cur_r.event_id; srec_r[vic_r] <= ctr_r;
                  scmp_r[vic_r] <= '0; sconn_r[vic_r] <= cur_r.conn_id;
                end
              end else if (r_i < vseq_r) begin
                vic_r  <= idx_r;
                vseq_r <= r_i;
              end
            end
            KIND_DESTROY: begin
              if (hit) begin
                sev_r[idx_r] <= '0; srec_r[idx_r] <= '0;
                scmp_r[idx_r] <= '0; sconn_r[idx_r] <= '0;
              end
            end
            KIND_QUERY: begin
              if (hit && r_i == cur_r.seq) scmp_r[idx_r] <= cur_r.seq;
            end
            default: ;
          endcase
          idx_r <= idx_r + 1'b1;
          if (done_i) st_r <= S_EMIT;
        end
        S_PRIM: begin
          if (prim_known) begin
            // Primary is already complete with nothing in flight.
            if (out_free) begin
              oev_r <= '0; oseq_r <= '0;
              olast_r <= 1'b1; oknown_r <= 1'b1; oissued_r <= issued_r;
              st_r <= S_IDLE;
            end
          end else if (hit) begin
            pseq_r <= r_i;
            idx_r  <= '0;
            st_r   <= S_OTHER;
          end else if (idx_end) begin
            idx_r <= '0;
            st_r  <= S_OTHER;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_OTHER: begin
          // Each batch entry is held back one step so that the final beat
          // can carry out_last.
          if (count_r == CMAX) begin
            st_r <= S_FLUSH;
          end else if (other_ok) begin
            if (out_free) begin
              oev_r <= hev_r; oseq_r <= pseq_r;
              olast_r <= 1'b0; oknown_r <= 1'b0; oissued_r <= issued_r;
              hev_r   <= e_i;
              pseq_r  <= r_i;
              count_r <= count_r + 1'b1;
              idx_r   <= idx_r + 1'b1;
              if (idx_end) st_r <= S_FLUSH;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            if (idx_end) st_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            oev_r <= hev_r; oseq_r <= pseq_r;
            olast_r <= 1'b1; oknown_r <= 1'b0; oissued_r <= issued_r;
            st_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            oev_r <= '0; oseq_r <= '0;
            olast_r <= 1'b1; oknown_r <= 1'b0; oissued_r <= issued_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |-> st_r == S_IDLE) else $error("request taken while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CMAX) else $error("batch exceeds table size");
  a_known_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oknown_r) |-> olast_r) else $error("known beat not last");
`endif

endmodule

>>> rtl/event_completion_tracker_core.sv
// Tracks up to SLOTS events by handle and answers record, destroy, collect,
// query-result and copy-counter requests. A queue of two requests separates
// the input from the table engine, which visits one slot per cycle unless an
// output stall holds it, and takes no new request until it is done with the
// last. A collect emits one result beat per batch entry, the last marked by
// out_last. The slot scan of the engine sets the rate.
module event_completion_tracker_core
  import ect_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KindW-1:0] in_kind,
  input  logic [EvW-1:0]   in_event_id,
  input  logic [ConnW-1:0] in_conn_id,
  input  logic [SeqW-1:0]  in_recorded_seq,
  input  logic             in_query_ok,
  input  logic [SeqW-1:0]  in_drained_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [EvW-1:0]   out_batch_event,
  output logic [SeqW-1:0]  out_batch_seq,
  output logic             out_last,
  output logic             out_known_locally,
  output logic [SeqW-1:0]  out_issued_count
);

  logic req_valid, req_take;
  req_t req;

  ect_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_event_id, .in_conn_id,
    .in_recorded_seq, .in_query_ok, .in_drained_count,
    .req_valid, .req, .req_take
  );

  ect_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .req_valid, .req, .req_take, .out_valid, .out_stall,
    .out_batch_event, .out_batch_seq, .out_last, .out_known_locally,
    .out_issued_count
  );

endmodule
